@@ hdl/pps_pkg.sv @@
package pps_pkg;

   // field and register widths
   localparam int FreqW    = 32;
   localparam int ClkW     = 32;
   localparam int LimW     = 16;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 32;
   localparam int NumW     = 32;
   localparam int DenW     = LimW + 1 + FreqW;
   localparam int DivSteps = NumW;

   // register reset values
   localparam logic [ClkW-1:0] ClkHzReset  = 32'd80000000;
   localparam logic [LimW-1:0] DividerReset = 16'h0000;
   localparam logic [LimW-1:0] PreLimReset  = 16'hFFFF;
   localparam logic [LimW-1:0] PerLimReset  = 16'hFFFF;

   // register indexes
   typedef enum logic [CsrIdxW-1:0] {
      CSR_INPUT_CLOCK_HZ  = 2'd0,
      CSR_CLOCK_DIVIDER   = 2'd1,
      CSR_PRESCALER_LIMIT = 2'd2,
      CSR_PERIOD_LIMIT    = 2'd3
   } csr_index_type;

   // values that travel with a word down the pipeline
   typedef struct packed {
      logic [FreqW-1:0] freq;
      logic [LimW-1:0]  pre_lim;
      logic [LimW-1:0]  per_lim;
      logic [NumW-1:0]  base;
      logic [NumW-1:0]  pre;
   } pps_side_type;

endpackage

@@ hdl/pps_div_pipe.sv @@
module pps_div_pipe (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  logic [pps_pkg::NumW-1:0] in_num,
   input  logic [pps_pkg::DenW-1:0] in_den,
   input  pps_pkg::pps_side_type    in_side,
   output logic                 out_valid,
   output logic [pps_pkg::NumW-1:0] out_quo,
   output pps_pkg::pps_side_type    out_side
);
   import pps_pkg::*;

   // one restoring step per stage, quotient bits shift in at the bottom of num
   logic                valid_ff [1:DivSteps];
   logic [DenW-1:0]     rem_ff   [1:DivSteps];
   logic [NumW-1:0]     num_ff   [1:DivSteps];
   logic [DenW-1:0]     den_ff   [1:DivSteps];
   pps_side_type        side_ff  [1:DivSteps];

   logic                valid_cur [0:DivSteps-1];
   logic [DenW-1:0]     rem_cur   [0:DivSteps-1];
   logic [NumW-1:0]     num_cur   [0:DivSteps-1];
   logic [DenW-1:0]     den_cur   [0:DivSteps-1];
   pps_side_type        side_cur  [0:DivSteps-1];

   assign valid_cur[0] = in_valid;
   assign rem_cur[0]   = '0;
   assign num_cur[0]   = in_num;
   assign den_cur[0]   = in_den;
   assign side_cur[0]  = in_side;

   genvar k;
   generate
      for (k = 1; k < DivSteps; k++) begin : g_src
         assign valid_cur[k] = valid_ff[k];
         assign rem_cur[k]   = rem_ff[k];
         assign num_cur[k]   = num_ff[k];
         assign den_cur[k]   = den_ff[k];
         assign side_cur[k]  = side_ff[k];
      end

      for (k = 0; k < DivSteps; k++) begin : g_step
         logic [DenW:0]   rem_sh;
         logic [DenW+1:0] diff;
         logic            ge;
         logic [DenW-1:0] rem_in;
         logic [NumW-1:0] num_in;

         // trial subtract of the divisor from the shifted remainder
         always_comb begin
            rem_sh = {rem_cur[k], num_cur[k][NumW-1]};
            diff   = {1'b0, rem_sh} - {2'b00, den_cur[k]};
            ge     = ~diff[DenW+1];
            rem_in = ge ? diff[DenW-1:0] : rem_sh[DenW-1:0];
            num_in = {num_cur[k][NumW-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k+1] <= 1'b0;
            end else if (enable) begin
               valid_ff[k+1] <= valid_cur[k];
            end
            if (enable) begin
               rem_ff[k+1]  <= rem_in;
               num_ff[k+1]  <= num_in;
               den_ff[k+1]  <= den_cur[k];
               side_ff[k+1] <= side_cur[k];
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[DivSteps];
   assign out_quo   = num_ff[DivSteps];
   assign out_side  = side_ff[DivSteps];

`ifndef SYNTHESIS
   // a frozen pipeline keeps its output word
   assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(out_valid))
      else $error("divider output valid moved while frozen");
   assert property (@(posedge clock) disable iff (reset)
      !enable && out_valid |=> $stable(out_quo))
      else $error("divider quotient moved while frozen");
   assert property (@(posedge clock) disable iff (reset)
      enable |=> out_valid == $past(valid_ff[DivSteps-1]))
      else $error("divider valid lost or invented");
`endif

endmodule

@@ hdl/pwm_prescaler_period_solver_core.sv @@
// Timer prescaler and period solver.
// The request channel (req_valid, req_stall, req_target_frequency) takes one
// requested frequency per word; the response channel (rsp_valid, rsp_stall,
// rsp_prescaler_value, rsp_period_value, rsp_ok) returns exactly one word for
// each request, in order. The csr_ port writes the clock, divider and limit
// registers; the user must use it only while no request is in flight; unchecked.
// The path runs through an entry register, three 32-step restoring divider
// pipelines (base clock, prescaler, period) of one step per stage, two
// multiplier registers and the output register. A word can enter on every
// cycle unless req_stall is raised, so throughput is one word per cycle.
// Reset clears all valid bits and loads the register reset values; no
// clearing pass is needed, requests are taken from the next cycle.
// When the receiver stalls a waiting response, the pipeline still advances
// until a finished word reaches its last divider stage; then the whole
// pipeline freezes and req_stall is raised until the response is taken.
module pwm_prescaler_period_solver_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [pps_pkg::FreqW-1:0] req_target_frequency,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [pps_pkg::LimW-1:0]  rsp_prescaler_value,
   output logic [pps_pkg::LimW-1:0]  rsp_period_value,
   output logic                      rsp_ok,
   input  logic                      csr_write_enable,
   input  logic [pps_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [pps_pkg::CsrDataW-1:0] csr_write_data
);
   import pps_pkg::*;

   // configuration registers
   logic [ClkW-1:0] clk_hz_ff;
   logic [LimW-1:0] divider_ff;
   logic [LimW-1:0] pre_lim_ff;
   logic [LimW-1:0] per_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff  <= ClkHzReset;
         divider_ff <= DividerReset;
         pre_lim_ff <= PreLimReset;
         per_lim_ff <= PerLimReset;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_INPUT_CLOCK_HZ:  clk_hz_ff  <= csr_write_data[ClkW-1:0];
            CSR_CLOCK_DIVIDER:   divider_ff <= csr_write_data[LimW-1:0];
            CSR_PRESCALER_LIMIT: pre_lim_ff <= csr_write_data[LimW-1:0];
            CSR_PERIOD_LIMIT:    per_lim_ff <= csr_write_data[LimW-1:0];
            default: ;
         endcase
      end
   end

   // pipeline advance: freeze only when a finished word would overrun the output
   logic enable;
   logic last_valid;
   logic hold;
   logic rsp_valid_ff;

   assign hold      = rsp_valid_ff && rsp_stall;
   assign enable    = !hold || !last_valid;
   assign req_stall = !enable;

   // entry stage
   logic            e_valid_ff;
   logic [ClkW-1:0] e_clk_ff;
   logic [LimW-1:0] e_div_ff;
   pps_side_type    e_side_ff;
   pps_side_type    e_side_in;

   always_comb begin
      e_side_in         = '0;
      e_side_in.freq    = req_target_frequency;
      e_side_in.pre_lim = pre_lim_ff;
      e_side_in.per_lim = per_lim_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (enable) begin
         e_valid_ff <= req_valid;
      end
      if (enable) begin
         e_clk_ff  <= clk_hz_ff;
         e_div_ff  <= divider_ff;
         e_side_ff <= e_side_in;
      end
   end

   // base clock = input clock / (divider + 1)
   logic            d1_valid;
   logic [NumW-1:0] d1_quo;
   pps_side_type    d1_side;
   logic [DenW-1:0] d1_den;

   assign d1_den = DenW'({1'b0, e_div_ff} + 17'd1);

   pps_div_pipe u_div_base (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (e_valid_ff),
      .in_num    (e_clk_ff),
      .in_den    (d1_den),
      .in_side   (e_side_ff),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_side  (d1_side)
   );

   // divisor for the prescaler: (period limit + 1) * frequency
   logic            m1_valid_ff;
   logic [DenW-1:0] m1_den_ff;
   pps_side_type    m1_side_ff;
   pps_side_type    m1_side_in;
   logic [LimW:0]   m1_fac;

   always_comb begin
      m1_side_in      = d1_side;
      m1_side_in.base = d1_quo;
      m1_fac          = {1'b0, d1_side.per_lim} + 17'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (enable) begin
         m1_valid_ff <= d1_valid;
      end
      if (enable) begin
         m1_den_ff  <= m1_fac * d1_side.freq;
         m1_side_ff <= m1_side_in;
      end
   end

   // prescaler = base / ((period limit + 1) * frequency)
   logic            d2_valid;
   logic [NumW-1:0] d2_quo;
   pps_side_type    d2_side;

   pps_div_pipe u_div_pre (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (m1_valid_ff),
      .in_num    (m1_side_ff.base),
      .in_den    (m1_den_ff),
      .in_side   (m1_side_ff),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_side  (d2_side)
   );

   // divisor for the period: (prescaler + 1) * frequency
   logic            m2_valid_ff;
   logic [DenW-1:0] m2_den_ff;
   pps_side_type    m2_side_ff;
   pps_side_type    m2_side_in;
   logic [LimW:0]   m2_fac;

   always_comb begin
      m2_side_in     = d2_side;
      m2_side_in.pre = d2_quo;
      m2_fac         = {1'b0, d2_quo[LimW-1:0]} + 17'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (enable) begin
         m2_valid_ff <= d2_valid;
      end
      if (enable) begin
         m2_den_ff  <= m2_fac * d2_side.freq;
         m2_side_ff <= m2_side_in;
      end
   end

   // period = base / ((prescaler + 1) * frequency)
   logic            d3_valid;
   logic [NumW-1:0] d3_quo;
   pps_side_type    d3_side;

   pps_div_pipe u_div_per (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (m2_valid_ff),
      .in_num    (m2_side_ff.base),
      .in_den    (m2_den_ff),
      .in_side   (m2_side_ff),
      .out_valid (d3_valid),
      .out_quo   (d3_quo),
      .out_side  (d3_side)
   );

   assign last_valid = d3_valid;

   // output word: zero frequency, clamped case or solved case
   logic            rsp_valid_in;
   logic [LimW-1:0] rsp_pre_ff;
   logic [LimW-1:0] rsp_pre_in;
   logic [LimW-1:0] rsp_per_ff;
   logic [LimW-1:0] rsp_per_in;
   logic            rsp_ok_ff;
   logic            rsp_ok_in;
   logic            fits;
   logic            nz;

   always_comb begin
      nz   = d3_side.freq != '0;
      fits = d3_side.pre <= {{(NumW-LimW){1'b0}}, d3_side.pre_lim};
      if (!nz) begin
         rsp_pre_in = '0;
         rsp_per_in = '0;
      end else if (fits) begin
         rsp_pre_in = d3_side.pre[LimW-1:0];
         rsp_per_in = d3_quo[LimW-1:0];
      end else begin
         rsp_pre_in = d3_side.pre_lim;
         rsp_per_in = d3_side.per_lim;
      end
      rsp_ok_in    = nz;
      rsp_valid_in = hold ? 1'b1 : last_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (!hold) begin
         rsp_pre_ff <= rsp_pre_in;
         rsp_per_ff <= rsp_per_in;
         rsp_ok_ff  <= rsp_ok_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_prescaler_value = rsp_pre_ff;
   assign rsp_period_value    = rsp_per_ff;
   assign rsp_ok              = rsp_ok_ff;

`ifndef SYNTHESIS
   // a rejected request never carries a nonzero result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_pre_ff == '0 && rsp_per_ff == '0)
      else $error("zero frequency gave a nonzero result");
   // a finished divider word is never dropped
   assert property (@(posedge clock) disable iff (reset)
      last_valid && enable |=> rsp_valid_ff)
      else $error("finished word lost at the output");
   // the pipeline never freezes without a waiting response
   assert property (@(posedge clock) disable iff (reset)
      !enable |-> rsp_valid_ff && last_valid)
      else $error("pipeline frozen without cause");
`endif

endmodule

@@ test/tb_pwm_prescaler_period_solver_core.sv @@
`timescale 1ns / 100ps

// expected timer settings, kept in request order
class pps_timing_board;
   logic [15:0] exp_pre[$];
   logic [15:0] exp_per[$];
   logic        exp_ok[$];
   int          n_errors;

   // solve one requested frequency and queue the expected word
   function void note_request(logic [31:0] freq, logic [31:0] clk_hz, logic [15:0] div,
                              logic [15:0] pre_lim, logic [15:0] per_lim);
      logic [63:0] base_clk, pre, per;
      if (freq == 0) begin
         exp_pre.push_back(16'd0);
         exp_per.push_back(16'd0);
         exp_ok.push_back(1'b0);
         return;
      end
      base_clk = 64'(clk_hz) / (64'(div) + 64'd1);
      pre = base_clk / ((64'(per_lim) + 64'd1) * 64'(freq));
      if (pre <= 64'(pre_lim)) begin
         per = base_clk / ((pre + 64'd1) * 64'(freq));
      end else begin
         pre = 64'(pre_lim);
         per = 64'(per_lim);
      end
      exp_pre.push_back(pre[15:0]);
      exp_per.push_back(per[15:0]);
      exp_ok.push_back(1'b1);
   endfunction

   // compare one response word with the oldest expectation
   function void check_response(logic [15:0] pre, logic [15:0] per, logic ok);
      if (exp_ok.size() == 0) begin
         n_errors++;
         if (n_errors <= 10) $display("unexpected response pre=%0d per=%0d ok=%0d",
                                      pre, per, ok);
         return;
      end
      if (pre !== exp_pre[0] || per !== exp_per[0] || ok !== exp_ok[0]) begin
         n_errors++;
         if (n_errors <= 10)
            $display("mismatch: exp pre=%0d per=%0d ok=%0d got pre=%0d per=%0d ok=%0d",
                     exp_pre[0], exp_per[0], exp_ok[0], pre, per, ok);
      end
      void'(exp_pre.pop_front());
      void'(exp_per.pop_front());
      void'(exp_ok.pop_front());
   endfunction

   function int pending();
      return exp_ok.size();
   endfunction
endclass

module tb_pwm_prescaler_period_solver_core;
   import pps_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [FreqW-1:0]    req_target_frequency = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [LimW-1:0]     rsp_prescaler_value;
   logic [LimW-1:0]     rsp_period_value;
   logic                rsp_ok;
   logic                csr_write_enable = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_write_data = '0;

   // testbench copy of the registers
   logic [31:0] clk_hz;
   logic [15:0] divider, pre_lim, per_lim;

   pps_timing_board board = new();
   bit stall_on = 1'b1;

   pwm_prescaler_period_solver_core i_dut (.*);

   always #10 clock = ~clock;

   // response check at each accepting edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_prescaler_value, rsp_period_value, rsp_ok);
   end

   // receiver stall pattern: quiet stretches, bursty stretches
   initial begin
      int mode;
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(20, 200)) begin
            @(posedge clock);
            if (!stall_on) rsp_stall <= 1'b0;
            else case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_INPUT_CLOCK_HZ: clk_hz = data;
         CSR_CLOCK_DIVIDER: divider = data[15:0];
         CSR_PRESCALER_LIMIT: pre_lim = data[15:0];
         default: per_lim = data[15:0];
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // hold one word until accepted; valid stays high between back-to-back words
   task automatic send_freq(logic [31:0] freq, bit keep);
      req_valid <= 1'b1;
      req_target_frequency <= freq;
      do @(posedge clock); while (req_stall);
      board.note_request(freq, clk_hz, divider, pre_lim, per_lim);
      if (!keep) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      while (board.pending() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_freq();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 3);
         1: return $urandom_range(1, 1000);
         2: return $urandom_range(1000, 200000);
         3: return $urandom >> $urandom_range(0, 31);
         4: return $urandom;
         default: return 32'hFFFFFFFF - $urandom_range(0, 3);
      endcase
   endfunction

   // random bursts under the current settings
   task automatic random_traffic(int count);
      int sent = 0;
      int len;
      while (sent < count) begin
         len = $urandom_range(1, 30);
         for (int k = 0; k < len && sent < count; k++) begin
            sent++;
            send_freq(rand_freq(), k != len - 1 && sent < count);
         end
         repeat ($urandom_range(0, 6)) @(posedge clock);
      end
   endtask

   initial begin
      logic [31:0] dirs[] = '{0, 1, 32'hFFFFFFFF, 1000, 20000, 1220, 1221, 2, 80000000,
                               80000001, 40000000, 32'h80000000, 32'h7FFFFFFF};
      clk_hz = ClkHzReset;
      divider = DividerReset;
      pre_lim = PreLimReset;
      per_lim = PerLimReset;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed words at reset settings
      foreach (dirs[i]) send_freq(dirs[i], i != dirs.size() - 1);
      drain();

      // tight limits so the no-fit clamp is reached
      write_csr(CSR_PRESCALER_LIMIT, 32'd3);
      write_csr(CSR_PERIOD_LIMIT, 32'd10);
      foreach (dirs[i]) send_freq(dirs[i], 1'b0);
      // sender pauses until every word has come back
      drain();

      // extremes: full clock, max divider, zero prescaler limit, period limit 1
      write_csr(CSR_INPUT_CLOCK_HZ, 32'hFFFFFFFF);
      write_csr(CSR_CLOCK_DIVIDER, 32'hFFFF);
      write_csr(CSR_PRESCALER_LIMIT, 32'h0);
      write_csr(CSR_PERIOD_LIMIT, 32'h1);
      random_traffic(150);
      drain();

      // zero period limit and zero clock corners
      write_csr(CSR_PERIOD_LIMIT, 32'h0);
      write_csr(CSR_CLOCK_DIVIDER, 32'h0);
      random_traffic(80);
      drain();
      write_csr(CSR_INPUT_CLOCK_HZ, 32'h0);
      write_csr(CSR_PERIOD_LIMIT, 32'hFFFF);
      random_traffic(40);
      drain();

      // random settings
      for (int s = 0; s < 7; s++) begin
         write_csr(CSR_INPUT_CLOCK_HZ, $urandom_range(0, 1) ? $urandom : $urandom_range(1, 200000000));
         write_csr(CSR_CLOCK_DIVIDER, $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom);
         write_csr(CSR_PRESCALER_LIMIT, $urandom);
         write_csr(CSR_PERIOD_LIMIT, $urandom_range(0, 1) ? $urandom_range(1, 255) : $urandom);
         random_traffic(110);
         drain();
      end

      // last stretch with a stall-free receiver
      stall_on = 1'b0;
      write_csr(CSR_INPUT_CLOCK_HZ, 32'd80000000);
      random_traffic(50);
      drain();

      if (board.n_errors == 0 && board.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #(30_000_000);
      $display("== FAIL ==");
      $finish;
   end

endmodule
